[rtl/mfm_pkg.sv]
// Shared types, layout constants and helper functions for the MFM track
// format generator. No dependencies.
package mfm_pkg;

    localparam int SECTOR_COUNT_DEFAULT = 9;
    localparam int TABLE_BYTES          = 128;
    localparam int PREAMBLE_END         = TABLE_BYTES + 80 + 12 + 4 + 50;
    localparam int SECTOR_BYTES         = 628;
    localparam int FE_OFFSET            = 15;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [13:0] TRACK_SIZE_RESET = 14'd6400;

    localparam logic [7:0] BYTE_GAP   = 8'h4E;
    localparam logic [7:0] BYTE_SYNC  = 8'h00;
    localparam logic [7:0] BYTE_A1    = 8'hA1;
    localparam logic [7:0] BYTE_IDAM  = 8'hFE;
    localparam logic [7:0] BYTE_DAM   = 8'hFB;
    localparam logic [7:0] BYTE_C2    = 8'hC2;
    localparam logic [7:0] BYTE_IAM   = 8'hFC;
    localparam logic [7:0] BYTE_SIZE  = 8'h02;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    // configuration register indexes
    localparam logic [1:0] REG_TRACK  = 2'd0;
    localparam logic [1:0] REG_SIDE   = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    typedef enum logic [1:0] {
        OP_PLAIN,
        OP_FEED,
        OP_CRC_HI,
        OP_CRC_LO
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  value;
        logic        preset;
        logic        take;
        logic [13:0] position;
        logic        last;
    } desc_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // pointer table byte for a given table offset; entry range check is
    // left to the caller
    function automatic logic [7:0] table_byte(input logic [6:0] pos);
        logic [15:0] ptr;
        ptr = 16'(PREAMBLE_END + FE_OFFSET) + 16'(pos[6:1]) * 16'(SECTOR_BYTES);
        ptr = 16'h8000 | (ptr & 16'h3FFF);
        return pos[0] ? ptr[15:8] : ptr[7:0];
    endfunction

    function automatic logic [7:0] preamble_byte(input logic [8:0] r);
        if (r < 9'd80)
            return BYTE_GAP;
        else if (r < 9'd92)
            return BYTE_SYNC;
        else if (r < 9'd95)
            return BYTE_C2;
        else if (r < 9'd96)
            return BYTE_IAM;
        else
            return BYTE_GAP;
    endfunction

endpackage

[rtl/mfm_track_format_generator.sv]
// MFM track format generator: one input beat in, one track image byte out.
// Sustains one byte per clock while pop keeps up; a pushed beat passes through
// front classification into the two-entry queue, then CRC and the output
// register. Each beat yields exactly one result beat; data_byte is used
// only where takes_data is set. Configuration is a write channel that is
// always ready; write only while the block is idle. No clearing pass.
// Depends on mfm_pkg, mfm_front, mfm_queue, mfm_back.
module mfm_track_format_generator #(
    parameter int SECTOR_COUNT = mfm_pkg::SECTOR_COUNT_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  track_byte,
    output logic [13:0] position,
    output logic        takes_data,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [13:0] cfg_data
);

    logic [7:0]     track_number_reg;
    logic           side_number_reg;
    logic [13:0]    track_size_reg;
    logic           accept;
    mfm_pkg::desc_t front_desc;
    mfm_pkg::desc_t queue_desc;
    logic           queue_valid;
    logic           queue_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_number_reg <= '0;
            side_number_reg  <= 1'b0;
            track_size_reg   <= mfm_pkg::TRACK_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mfm_pkg::REG_TRACK:  track_number_reg <= cfg_data[7:0];
                mfm_pkg::REG_SIDE:   side_number_reg  <= cfg_data[0];
                mfm_pkg::REG_LENGTH: track_size_reg   <= cfg_data;
                default:             ;
            endcase
        end
    end

    mfm_front #(
        .SECTOR_COUNT(SECTOR_COUNT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .track_number (track_number_reg),
        .side_number  (side_number_reg),
        .track_size   (track_size_reg),
        .desc         (front_desc)
    );

    mfm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept),
        .wr_data  (front_desc),
        .full     (full),
        .rd_en    (queue_pop),
        .rd_valid (queue_valid),
        .rd_data  (queue_desc)
    );

    mfm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (queue_valid),
        .desc       (queue_desc),
        .desc_pop   (queue_pop),
        .empty      (empty),
        .pop        (pop),
        .track_byte (track_byte),
        .position   (position),
        .takes_data (takes_data),
        .last       (last)
    );

endmodule

[rtl/mfm_front.sv]
// Front end: accepts input beats, tracks position, sector and offset, and
// classifies each byte into a descriptor. Depends on mfm_pkg.
module mfm_front #(
    parameter int SECTOR_COUNT = mfm_pkg::SECTOR_COUNT_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          data_byte,
    input  logic [7:0]          track_number,
    input  logic                side_number,
    input  logic [13:0]         track_size,
    output mfm_pkg::desc_t      desc
);

    localparam int SecW = $clog2(SECTOR_COUNT + 1);

    logic [13:0]     pos_reg, pos_next;
    logic [9:0]      off_reg, off_next;
    logic [SecW-1:0] sec_reg, sec_next;
    logic            last;
    logic            in_table, in_preamble;

    assign in_table    = pos_reg < 14'(mfm_pkg::TABLE_BYTES);
    assign in_preamble = pos_reg < 14'(mfm_pkg::PREAMBLE_END);
    assign last = ({1'b0, pos_reg} + 15'd1) >= {1'b0, track_size};

    always_comb begin
        desc          = '0;
        desc.op       = mfm_pkg::OP_PLAIN;
        desc.value    = mfm_pkg::BYTE_GAP;
        desc.position = pos_reg;
        desc.last     = last;
        if (in_table) begin
            if (pos_reg[6:1] < 6'(SECTOR_COUNT))
                desc.value = mfm_pkg::table_byte(pos_reg[6:0]);
            else
                desc.value = 8'h00;
        end else if (in_preamble) begin
            desc.value = mfm_pkg::preamble_byte(9'(pos_reg - 14'(mfm_pkg::TABLE_BYTES)));
        end else if (sec_reg < SecW'(SECTOR_COUNT)) begin
            if (off_reg < 10'd12) begin
                desc.value = mfm_pkg::BYTE_SYNC;
            end else if (off_reg < 10'd20) begin
                desc.op     = mfm_pkg::OP_FEED;
                desc.preset = off_reg == 10'd12;
                if (off_reg < 10'd15)
                    desc.value = mfm_pkg::BYTE_A1;
                else if (off_reg == 10'd15)
                    desc.value = mfm_pkg::BYTE_IDAM;
                else if (off_reg == 10'd16)
                    desc.value = track_number;
                else if (off_reg == 10'd17)
                    desc.value = {7'd0, side_number};
                else if (off_reg == 10'd18)
                    desc.value = 8'(sec_reg) + 8'd1;
                else
                    desc.value = mfm_pkg::BYTE_SIZE;
            end else if (off_reg == 10'd20) begin
                desc.op = mfm_pkg::OP_CRC_HI;
            end else if (off_reg == 10'd21) begin
                desc.op = mfm_pkg::OP_CRC_LO;
            end else if (off_reg < 10'd44) begin
                desc.value = mfm_pkg::BYTE_GAP;
            end else if (off_reg < 10'd56) begin
                desc.value = mfm_pkg::BYTE_SYNC;
            end else if (off_reg < 10'd572) begin
                desc.op     = mfm_pkg::OP_FEED;
                desc.preset = off_reg == 10'd56;
                if (off_reg < 10'd59) begin
                    desc.value = mfm_pkg::BYTE_A1;
                end else if (off_reg == 10'd59) begin
                    desc.value = mfm_pkg::BYTE_DAM;
                end else begin
                    desc.value = data_byte;
                    desc.take  = 1'b1;
                end
            end else if (off_reg == 10'd572) begin
                desc.op = mfm_pkg::OP_CRC_HI;
            end else if (off_reg == 10'd573) begin
                desc.op = mfm_pkg::OP_CRC_LO;
            end
        end
    end

    always_comb begin
        pos_next = pos_reg;
        off_next = off_reg;
        sec_next = sec_reg;
        if (accept) begin
            if (last) begin
                pos_next = '0;
                off_next = '0;
                sec_next = '0;
            end else begin
                pos_next = pos_reg + 14'd1;
                if (!in_preamble) begin
                    if (off_reg == 10'(mfm_pkg::SECTOR_BYTES - 1)) begin
                        off_next = '0;
                        // saturate once past the last sector: rest is fill
                        if (sec_reg != SecW'(SECTOR_COUNT))
                            sec_next = sec_reg + SecW'(1);
                    end else begin
                        off_next = off_reg + 10'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            off_reg <= '0;
            sec_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            off_reg <= off_next;
            sec_reg <= sec_next;
        end
    end

endmodule

[rtl/mfm_queue.sv]
// Short descriptor queue between front and back end. Depends on mfm_pkg.
module mfm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  mfm_pkg::desc_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output logic           rd_valid,
    output mfm_pkg::desc_t rd_data
);

    localparam int PtrW = $clog2(mfm_pkg::QUEUE_DEPTH);

    mfm_pkg::desc_t mem [mfm_pkg::QUEUE_DEPTH];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   count_reg, count_next;

    assign full     = count_reg == (PtrW+1)'(mfm_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        if (p == PtrW'(mfm_pkg::QUEUE_DEPTH - 1))
            return '0;
        else
            return p + PtrW'(1);
    endfunction

    always_comb begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + (PtrW+1)'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - (PtrW+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/mfm_back.sv]
// Back end: runs the CRC over descriptors in order and holds the result
// beat in an output register. Depends on mfm_pkg.
module mfm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           desc_valid,
    input  mfm_pkg::desc_t desc,
    output logic           desc_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     track_byte,
    output logic [13:0]    position,
    output logic           takes_data,
    output logic           last
);

    logic [15:0] crc_reg, crc_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic [13:0] pos_reg;
    logic        take_reg;
    logic        last_reg;
    logic [15:0] crc_base;

    assign desc_pop = desc_valid && (!valid_reg || pop);
    assign crc_base = desc.preset ? mfm_pkg::CRC_PRESET : crc_reg;

    always_comb begin
        crc_next  = crc_reg;
        byte_next = desc.value;
        case (desc.op)
            mfm_pkg::OP_FEED:   crc_next  = mfm_pkg::crc_update(crc_base, desc.value);
            mfm_pkg::OP_CRC_HI: byte_next = crc_reg[15:8];
            mfm_pkg::OP_CRC_LO: byte_next = crc_reg[7:0];
            default:            byte_next = desc.value;
        endcase
        if (desc.last)
            crc_next = mfm_pkg::CRC_PRESET;

        valid_next = valid_reg;
        if (desc_pop)
            valid_next = 1'b1;
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mfm_pkg::CRC_PRESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (desc_pop)
                crc_reg <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_pop)
        begin
            byte_reg <= byte_next;
            pos_reg  <= desc.position;
            take_reg <= desc.take;
            last_reg <= desc.last;
        end
    end

    assign empty      = !valid_reg;
    assign track_byte = byte_reg;
    assign position   = pos_reg;
    assign takes_data = take_reg;
    assign last       = last_reg;

endmodule
